### design/hkv_pkg.sv
// Shared constants, types and the bucket hash for the key-value cache.
package hkv_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = 6;
  localparam int LINK_W   = 7;
  localparam int BKT_W    = 4;
  localparam int BUCKETS  = 16;

  localparam logic [LINK_W-1:0] NIL = 7'd64;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic                key_we;
    logic [SLOT_W-1:0]   key_addr;
    logic [63:0]         key_data;
    logic                val_we;
    logic [SLOT_W-1:0]   val_addr;
    logic [63:0]         val_data;
    logic                lnk_we;
    logic [SLOT_W-1:0]   lnk_addr;
    logic [LINK_W-1:0]   lnk_data;
    logic                old_we;
    logic [SLOT_W-1:0]   old_addr;
    logic [LINK_W-1:0]   old_data;
    logic                yng_we;
    logic [SLOT_W-1:0]   yng_addr;
    logic [LINK_W-1:0]   yng_data;
  } mem_wr_t;

  typedef struct packed {
    logic [63:0]       key;
    logic [63:0]       val;
    logic [LINK_W-1:0] lnk;
    logic [LINK_W-1:0] old;
    logic [LINK_W-1:0] yng;
  } mem_rd_t;

  // djb2 mod 16: 33 = 1 mod 16, so only the low nibbles of the bytes matter.
  // 5381 mod 16 = 5.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] k);
    logic [BKT_W-1:0] h;
    h = 4'd5;
    for (int i = 0; i < 8; i++) begin
      h = h + k[8*i +: 4];
    end
    return h;
  endfunction

endpackage

### design/hkv_mem.sv
// Slot memories: keys, values, chain links and age links, one shared read port.
module hkv_mem (
  input  logic                            clk,
  input  logic [hkv_pkg::SLOT_W-1:0]      rd_addr,
  input  hkv_pkg::mem_wr_t                wr,
  output hkv_pkg::mem_rd_t                rd
);

  logic [63:0]               key_mem [hkv_pkg::CAPACITY];
  logic [63:0]               val_mem [hkv_pkg::CAPACITY];
  logic [hkv_pkg::LINK_W-1:0] lnk_mem [hkv_pkg::CAPACITY];
  logic [hkv_pkg::LINK_W-1:0] old_mem [hkv_pkg::CAPACITY];
  logic [hkv_pkg::LINK_W-1:0] yng_mem [hkv_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.key_we) key_mem[wr.key_addr] <= wr.key_data;
    if (wr.val_we) val_mem[wr.val_addr] <= wr.val_data;
    if (wr.lnk_we) lnk_mem[wr.lnk_addr] <= wr.lnk_data;
    if (wr.old_we) old_mem[wr.old_addr] <= wr.old_data;
    if (wr.yng_we) yng_mem[wr.yng_addr] <= wr.yng_data;
    rd.key <= key_mem[rd_addr];
    rd.val <= val_mem[rd_addr];
    rd.lnk <= lnk_mem[rd_addr];
    rd.old <= old_mem[rd_addr];
    rd.yng <= yng_mem[rd_addr];
  end

endmodule

### design/hashed_kv_cache_oldest_eviction.sv
// Top level: sequencer for the hashed key-value cache with oldest-first eviction.
// Usage:
//   Raise start with in_op, in_lookup_key and in_new_value while busy is low;
//   the item is taken at that edge and busy rises. Ops: get, insert/update,
//   delete, clear all.
//   One result comes back on out_hit, out_read_value, out_evicted and
//   out_occupancy, marked by out_valid for exactly one cycle; there is no
//   backpressure on the result side. The next item may be started in the
//   same cycle the result is shown.
// Sequence: each bucket chain step is a memory read state (S_WRD) and a
//   compare state (S_WCMP), since slot storage sits in single-read-port
//   memories with a registered read. A found get ends there; a delete then
//   unlinks the slot (S_RMV); an update moves it to youngest (S_UNL, S_APP1,
//   S_APP2). A new-key insert fills a free slot at the chain tail (S_FILL1,
//   S_FILL2) and appends it; a full store first reads the oldest slot's key
//   (S_EVRD, S_EVKEY), walks to that victim, removes it and re-walks the
//   key's chain (S_RSTART). Clear goes straight to the result (S_FIN).
// Reset: rst_n low clears the store (no used slots, empty buckets and age
//   list, zero occupancy) synchronously; no clearing pass is needed.
module hashed_kv_cache_oldest_eviction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_lookup_key,
  input  logic [63:0] in_new_value,
  output logic        out_valid,
  output logic        out_hit,
  output logic [63:0] out_read_value,
  output logic        out_evicted,
  output logic [6:0]  out_occupancy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRD    = 4'd1;
  localparam logic [3:0] S_WCMP   = 4'd2;
  localparam logic [3:0] S_RMV    = 4'd3;
  localparam logic [3:0] S_EVRD   = 4'd4;
  localparam logic [3:0] S_EVKEY  = 4'd5;
  localparam logic [3:0] S_RSTART = 4'd6;
  localparam logic [3:0] S_FILL1  = 4'd7;
  localparam logic [3:0] S_FILL2  = 4'd8;
  localparam logic [3:0] S_UNL    = 4'd9;
  localparam logic [3:0] S_APP1   = 4'd10;
  localparam logic [3:0] S_APP2   = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  localparam int SW = hkv_pkg::SLOT_W;
  localparam int LW = hkv_pkg::LINK_W;
  localparam int BW = hkv_pkg::BKT_W;

  logic [3:0]    state_r;
  logic [1:0]    op_r;
  logic [63:0]   key_r;
  logic [63:0]   val_r;
  logic [BW-1:0] kbkt_r;
  logic [BW-1:0] bucket_r;
  logic [LW-1:0] cur_r;
  logic [LW-1:0] prev_r;
  logic [SW-1:0] slot_r;
  logic [LW-1:0] o_r;
  logic [LW-1:0] y_r;
  logic [LW-1:0] lnk_r;
  logic          evmode_r;
  logic          ev_r;
  logic [hkv_pkg::CAPACITY-1:0] used_r;
  logic [LW-1:0] bfirst_r [hkv_pkg::BUCKETS];
  logic [LW-1:0] oldest_r;
  logic [LW-1:0] youngest_r;
  logic [6:0]    count_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [63:0]   out_rv_r;
  logic          out_ev_r;
  logic [6:0]    out_occ_r;

  hkv_pkg::mem_wr_t wr;
  hkv_pkg::mem_rd_t rd;
  logic [SW-1:0]    rd_addr;
  logic [BW-1:0]    bf_raddr;
  logic [LW-1:0]    bf_rd;
  logic             match;
  logic [SW-1:0]    free_idx;
  logic             have_free;

  hkv_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rv_r;
  assign out_evicted    = out_ev_r;
  assign out_occupancy  = out_occ_r;

  assign rd_addr = (state_r == S_EVRD) ? oldest_r[SW-1:0] : cur_r[SW-1:0];

  // eviction walk looks for the victim slot; normal walk compares keys
  assign match = evmode_r ? (cur_r == oldest_r) : (rd.key == key_r);

  always_comb begin
    unique case (state_r)
      S_IDLE:  bf_raddr = hkv_pkg::bucket_of(in_lookup_key);
      S_EVKEY: bf_raddr = hkv_pkg::bucket_of(rd.key);
      default: bf_raddr = kbkt_r;
    endcase
  end
  assign bf_rd = bfirst_r[bf_raddr];

  // lowest unused slot
  always_comb begin
    free_idx  = '0;
    have_free = 1'b0;
    for (int i = hkv_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx  = SW'(i);
        have_free = 1'b1;
      end
    end
  end

  always_comb begin
    wr = '0;
    unique case (state_r)
      S_WCMP: begin
        if (match && !evmode_r && op_r == hkv_pkg::OP_INSERT) begin
          wr.val_we   = 1'b1;
          wr.val_addr = cur_r[SW-1:0];
          wr.val_data = val_r;
        end
      end
      S_RMV, S_UNL: begin
        if (state_r == S_RMV && prev_r != hkv_pkg::NIL) begin
          wr.lnk_we   = 1'b1;
          wr.lnk_addr = prev_r[SW-1:0];
          wr.lnk_data = lnk_r;
        end
        if (o_r != hkv_pkg::NIL) begin
          wr.yng_we   = 1'b1;
          wr.yng_addr = o_r[SW-1:0];
          wr.yng_data = y_r;
        end
        if (y_r != hkv_pkg::NIL) begin
          wr.old_we   = 1'b1;
          wr.old_addr = y_r[SW-1:0];
          wr.old_data = o_r;
        end
      end
      S_FILL1: begin
        if (have_free) begin
          wr.key_we   = 1'b1;
          wr.key_addr = free_idx;
          wr.key_data = key_r;
          wr.val_we   = 1'b1;
          wr.val_addr = free_idx;
          wr.val_data = val_r;
          wr.lnk_we   = 1'b1;
          wr.lnk_addr = free_idx;
          wr.lnk_data = hkv_pkg::NIL;
        end
      end
      S_FILL2: begin
        if (prev_r != hkv_pkg::NIL) begin
          wr.lnk_we   = 1'b1;
          wr.lnk_addr = prev_r[SW-1:0];
          wr.lnk_data = {1'b0, slot_r};
        end
      end
      S_APP1: begin
        wr.old_we   = 1'b1;
        wr.old_addr = slot_r;
        wr.old_data = youngest_r;
        wr.yng_we   = 1'b1;
        wr.yng_addr = slot_r;
        wr.yng_data = hkv_pkg::NIL;
      end
      S_APP2: begin
        if (youngest_r != hkv_pkg::NIL) begin
          wr.yng_we   = 1'b1;
          wr.yng_addr = youngest_r[SW-1:0];
          wr.yng_data = {1'b0, slot_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      for (int i = 0; i < hkv_pkg::BUCKETS; i++) bfirst_r[i] <= hkv_pkg::NIL;
      oldest_r    <= hkv_pkg::NIL;
      youngest_r  <= hkv_pkg::NIL;
      count_r     <= '0;
      evmode_r    <= 1'b0;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r      <= in_op;
            key_r     <= in_lookup_key;
            val_r     <= in_new_value;
            kbkt_r    <= bf_raddr;
            bucket_r  <= bf_raddr;
            cur_r     <= bf_rd;
            prev_r    <= hkv_pkg::NIL;
            evmode_r  <= 1'b0;
            ev_r      <= 1'b0;
            out_hit_r <= 1'b0;
            out_rv_r  <= '0;
            out_ev_r  <= 1'b0;
            if (in_op == hkv_pkg::OP_CLEAR) begin
              used_r     <= '0;
              for (int i = 0; i < hkv_pkg::BUCKETS; i++) bfirst_r[i] <= hkv_pkg::NIL;
              oldest_r   <= hkv_pkg::NIL;
              youngest_r <= hkv_pkg::NIL;
              count_r    <= '0;
              state_r    <= S_FIN;
            end else begin
              state_r <= S_WRD;
            end
          end
        end
        S_WRD: begin
          if (cur_r == hkv_pkg::NIL) begin
            if (evmode_r) begin
              state_r <= S_RSTART;
            end else if (op_r != hkv_pkg::OP_INSERT) begin
              state_r <= S_FIN;
            end else if (!ev_r && count_r[6] && oldest_r != hkv_pkg::NIL) begin
              state_r <= S_EVRD;
            end else begin
              state_r <= S_FILL1;
            end
          end else begin
            state_r <= S_WCMP;
          end
        end
        S_WCMP: begin
          o_r   <= rd.old;
          y_r   <= rd.yng;
          lnk_r <= rd.lnk;
          if (match) begin
            slot_r <= cur_r[SW-1:0];
            if (evmode_r) begin
              state_r <= S_RMV;
            end else begin
              unique case (op_r)
                hkv_pkg::OP_GET: begin
                  out_hit_r <= 1'b1;
                  out_rv_r  <= rd.val;
                  state_r   <= S_FIN;
                end
                hkv_pkg::OP_DELETE: begin
                  out_hit_r <= 1'b1;
                  state_r   <= S_RMV;
                end
                default: begin
                  out_hit_r <= 1'b1;
                  state_r   <= S_UNL;
                end
              endcase
            end
          end else begin
            prev_r  <= cur_r;
            cur_r   <= rd.lnk;
            state_r <= S_WRD;
          end
        end
        S_RMV: begin
          if (prev_r == hkv_pkg::NIL) bfirst_r[bucket_r] <= lnk_r;
          if (o_r == hkv_pkg::NIL) oldest_r <= y_r;
          if (y_r == hkv_pkg::NIL) youngest_r <= o_r;
          used_r[slot_r] <= 1'b0;
          if (count_r != '0) count_r <= count_r - 7'd1;
          if (evmode_r) begin
            ev_r     <= 1'b1;
            out_ev_r <= 1'b1;
            state_r  <= S_RSTART;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_EVRD: begin
          state_r <= S_EVKEY;
        end
        S_EVKEY: begin
          bucket_r <= bf_raddr;
          cur_r    <= bf_rd;
          prev_r   <= hkv_pkg::NIL;
          evmode_r <= 1'b1;
          state_r  <= S_WRD;
        end
        S_RSTART: begin
          // re-walk the key's chain to find its tail after the eviction
          evmode_r <= 1'b0;
          ev_r     <= 1'b1;
          bucket_r <= kbkt_r;
          cur_r    <= bf_rd;
          prev_r   <= hkv_pkg::NIL;
          state_r  <= S_WRD;
        end
        S_FILL1: begin
          if (have_free) begin
            slot_r         <= free_idx;
            used_r[free_idx] <= 1'b1;
            state_r        <= S_FILL2;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FILL2: begin
          if (prev_r == hkv_pkg::NIL) bfirst_r[bucket_r] <= {1'b0, slot_r};
          count_r <= count_r + 7'd1;
          state_r <= S_APP1;
        end
        S_UNL: begin
          if (o_r == hkv_pkg::NIL) oldest_r <= y_r;
          if (y_r == hkv_pkg::NIL) youngest_r <= o_r;
          state_r <= S_APP1;
        end
        S_APP1: begin
          state_r <= S_APP2;
        end
        S_APP2: begin
          if (youngest_r == hkv_pkg::NIL) oldest_r <= {1'b0, slot_r};
          youngest_r <= {1'b0, slot_r};
          state_r    <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_occ_r   <= count_r;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/hashed_kv_cache_oldest_eviction_tb.sv
// Testbench for the hashed key-value cache with oldest-first eviction.
`timescale 1ns / 100ps

module hashed_kv_cache_oldest_eviction_tb;

  typedef struct {
    logic        hit;
    logic [63:0] read_value;
    logic        evicted;
    logic [6:0]  occupancy;
  } kv_result_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Keeps its own copy of the store and queues the expected result per item.
  class kv_scoreboard;
    logic [63:0] keys[hkv_pkg::CAPACITY];
    logic [63:0] vals[hkv_pkg::CAPACITY];
    bit          used[hkv_pkg::CAPACITY];
    int          stamp[hkv_pkg::CAPACITY];
    int          bucket_chain[hkv_pkg::BUCKETS][$];
    int          count;
    int          next_stamp;
    kv_result_t  pending[$];

    function new();
      wipe();
    endfunction

    function void wipe();
      foreach (used[i]) used[i] = 0;
      foreach (bucket_chain[b]) bucket_chain[b].delete();
      count = 0;
    endfunction

    function int djb2_bucket(logic [63:0] k);
      logic [63:0] h;
      h = 64'd5381;
      for (int i = 7; i >= 0; i--) h = (h << 5) + h + k[8*i +: 8];
      return int'(h % hkv_pkg::BUCKETS);
    endfunction

    function int chain_pos(int b, logic [63:0] k);
      for (int i = 0; i < bucket_chain[b].size(); i++)
        if (keys[bucket_chain[b][i]] == k) return i;
      return -1;
    endfunction

    function void drop_slot(int s);
      int b, p;
      b = djb2_bucket(keys[s]);
      p = chain_pos(b, keys[s]);
      bucket_chain[b].delete(p);
      used[s] = 0;
      count--;
    endfunction

    function void note_item(logic [1:0] op, logic [63:0] k, logic [63:0] v);
      kv_result_t r;
      int b, p, s, oldest;
      r = '{0, 64'd0, 0, 7'd0};
      b = djb2_bucket(k);
      p = chain_pos(b, k);
      s = (p >= 0) ? bucket_chain[b][p] : -1;
      case (op)
        hkv_pkg::OP_CLEAR: wipe();
        hkv_pkg::OP_GET: if (s >= 0) begin
          r.hit = 1;
          r.read_value = vals[s];
        end
        hkv_pkg::OP_DELETE: if (s >= 0) begin
          r.hit = 1;
          drop_slot(s);
        end
        default: if (s >= 0) begin
          r.hit = 1;
          vals[s] = v;
          stamp[s] = next_stamp++;
        end else begin
          if (count >= hkv_pkg::CAPACITY) begin
            oldest = -1;
            for (int i = 0; i < hkv_pkg::CAPACITY; i++)
              if (used[i] && (oldest < 0 || stamp[i] < stamp[oldest])) oldest = i;
            drop_slot(oldest);
            r.evicted = 1;
          end
          for (s = 0; s < hkv_pkg::CAPACITY; s++) if (!used[s]) break;
          keys[s] = k;
          vals[s] = v;
          used[s] = 1;
          stamp[s] = next_stamp++;
          bucket_chain[b].push_back(s);
          count++;
        end
      endcase
      r.occupancy = count[6:0];
      pending.push_back(r);
    endfunction

    task check_result(input logic hit, input logic [63:0] rv, input logic ev,
                      input logic [6:0] occ);
      kv_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
      if (rv !== e.read_value) report_mismatch("read_value", rv, e.read_value);
      if (ev !== e.evicted) report_mismatch("evicted", ev, e.evicted);
      if (occ !== e.occupancy) report_mismatch("occupancy", occ, e.occupancy);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_op = hkv_pkg::OP_GET;
  logic [63:0] in_lookup_key = 0;
  logic [63:0] in_new_value = 0;
  logic        out_valid;
  logic        out_hit;
  logic [63:0] out_read_value;
  logic        out_evicted;
  logic [6:0]  out_occupancy;

  kv_scoreboard board = new();
  logic [63:0]  key_pool[32];
  bit           no_gaps = 0;
  longint       cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  hashed_kv_cache_oldest_eviction dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      board.check_result(out_hit, out_read_value, out_evicted, out_occupancy);
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Holds start until the item is taken, then optionally idles.
  task automatic issue(input logic [1:0] op, input logic [63:0] k, input logic [63:0] v);
    start <= 1;
    in_op <= op;
    in_lookup_key <= k;
    in_new_value <= v;
    do @(posedge clk); while (busy);
    board.note_item(op, k, v);
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 16) begin
      start <= 0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  function automatic logic [63:0] pick_key();
    return ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(31)];
  endfunction

  initial begin
    int r;
    logic [1:0] op;
    foreach (key_pool[i]) key_pool[i] = rand64();
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, miss paths, update, delete, clear
    issue(hkv_pkg::OP_GET, 64'd0, 64'd0);
    issue(hkv_pkg::OP_INSERT, 64'd0, '1);
    issue(hkv_pkg::OP_INSERT, '1, 64'd0);
    issue(hkv_pkg::OP_GET, 64'd0, 64'd0);
    issue(hkv_pkg::OP_GET, '1, '1);
    issue(hkv_pkg::OP_INSERT, 64'd0, 64'h5555_aaaa_5555_aaaa);
    issue(hkv_pkg::OP_GET, 64'd0, 64'd0);
    issue(hkv_pkg::OP_DELETE, 64'h10, 64'd0);
    issue(hkv_pkg::OP_DELETE, '1, 64'd0);
    issue(hkv_pkg::OP_GET, '1, 64'd0);
    // same bucket chain: keys differing by 16 in low byte
    issue(hkv_pkg::OP_INSERT, 64'h20, 64'd1);
    issue(hkv_pkg::OP_INSERT, 64'h30, 64'd2);
    issue(hkv_pkg::OP_DELETE, 64'h20, 64'd0);
    issue(hkv_pkg::OP_GET, 64'h30, 64'd0);
    issue(hkv_pkg::OP_CLEAR, '1, '1);
    issue(hkv_pkg::OP_GET, 64'h30, 64'd0);
    // fill past capacity to force evictions
    for (int i = 0; i < 68; i++) issue(hkv_pkg::OP_INSERT, 64'h100 + i, rand64());
    issue(hkv_pkg::OP_GET, 64'h100, 64'd0);

    for (int n = 0; n < 1580; n++) begin
      no_gaps = (n >= 800 && n < 1000);
      r = $urandom_range(99);
      op = (r < 45) ? hkv_pkg::OP_INSERT : (r < 75) ? hkv_pkg::OP_GET :
           (r < 99) ? hkv_pkg::OP_DELETE : hkv_pkg::OP_CLEAR;
      // periodic fill to keep the store near full
      if (n % 400 == 200)
        for (int i = 0; i < 70; i++) issue(hkv_pkg::OP_INSERT, rand64(), rand64());
      issue(op, (r < 35 || r >= 99) ? rand64() : pick_key(), rand64());
    end
    start <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
design/hkv_pkg.sv
design/hkv_mem.sv
design/hashed_kv_cache_oldest_eviction.sv
sim/hashed_kv_cache_oldest_eviction_tb.sv
